// ===== rtl/dltq_pkg.sv =====
// Package for the delta list timer queue: word types, sizes and result codes.
// No dependencies.
package dltq_pkg;
   localparam int DEPTH = 16;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   localparam logic REQ_TICK = 1'b0;
   localparam logic REQ_SET  = 1'b1;

   localparam logic [1:0] KIND_SET_OK   = 2'd0;
   localparam logic [1:0] KIND_SET_FULL = 2'd1;
   localparam logic [1:0] KIND_EXPIRED  = 2'd2;

   typedef struct packed {
      logic        req_type;
      logic [7:0]  tmr_key;
      logic [31:0] duration;
   } req_word_type;

   typedef struct packed {
      logic [1:0] result_kind;
      logic [7:0] result_id;
      logic       last;
   } rsp_word_type;

   typedef struct packed {
      logic [31:0] delta;
      logic [7:0]  id;
   } entry_type;
endpackage

// ===== rtl/dltq_store.sv =====
// Timer list store: one synchronous memory of delta/id entries, registered read.
// Depends on dltq_pkg.
module dltq_store (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [dltq_pkg::IDX_W-1:0] wr_addr,
   input  dltq_pkg::entry_type   wr_data,
   input  logic [dltq_pkg::IDX_W-1:0] rd_addr,
   output dltq_pkg::entry_type   rd_data
);
   import dltq_pkg::*;

   entry_type mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

// ===== rtl/delta_list_timer_queue.sv =====
// Delta list timer queue top level: sequencer around the list store.
// Depends on dltq_pkg and dltq_store.
//
// channel  ports             direction  handshake
// request  req_word          in         start & !busy
// response rsp_word          out        rsp_strobe, one cycle, no stall
//
// A set reads and checks entries up to the insertion point, then shifts the
// later entries back one slot (a read and a write each) and inserts; a full
// store replies at once. A tick reads and checks entries from the head, then
// moves the remaining entries forward (a read and a write each) and finishes.
// Each word is registered out of the state that makes it. The receiver cannot stall.
// Reset empties the list at once; no clearing pass.
module delta_list_timer_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  dltq_pkg::req_word_type req_word,
   output logic                   rsp_strobe,
   output dltq_pkg::rsp_word_type rsp_word
);
   import dltq_pkg::*;

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_SRD   = 4'd1;
   localparam logic [3:0] ST_SCHK  = 4'd2;
   localparam logic [3:0] ST_SHRD  = 4'd3;
   localparam logic [3:0] ST_SHWR  = 4'd4;
   localparam logic [3:0] ST_SINS  = 4'd5;
   localparam logic [3:0] ST_TRD   = 4'd6;
   localparam logic [3:0] ST_TCHK  = 4'd7;
   localparam logic [3:0] ST_MVRD  = 4'd8;
   localparam logic [3:0] ST_MVWR  = 4'd9;

   logic [3:0]        state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  pos_ff, pos_in;
   logic [CNT_W-1:0]  ptr_ff, ptr_in;
   logic [CNT_W-1:0]  nexp_ff, nexp_in;
   logic [31:0]       rem_ff, rem_in;
   logic [7:0]        id_ff, id_in;
   logic              first_ff, first_in;
   logic              pend_ff, pend_in;
   rsp_word_type      pword_ff, pword_in;
   logic              strobe_ff, strobe_in;
   rsp_word_type      rsp_ff, rsp_in;
   logic              expired;

   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr, rd_addr;
   entry_type         wr_data, rd_data;

   dltq_store u_store (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = strobe_ff;
   assign rsp_word   = rsp_ff;

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      pos_in    = pos_ff;
      ptr_in    = ptr_ff;
      nexp_in   = nexp_ff;
      rem_in    = rem_ff;
      id_in     = id_ff;
      first_in  = first_ff;
      pend_in   = pend_ff;
      pword_in  = pword_ff;
      strobe_in = 1'b0;
      rsp_in    = rsp_ff;
      expired   = 1'b0;
      wr_en     = 1'b0;
      wr_addr   = '0;
      wr_data   = '0;
      rd_addr   = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               id_in  = req_word.tmr_key;
               rem_in = req_word.duration;
               pos_in = '0;
               if (req_word.req_type == REQ_SET) begin
                  if (count_ff >= CNT_W'(DEPTH)) begin
                     strobe_in = 1'b1;
                     rsp_in    = '{KIND_SET_FULL, req_word.tmr_key, 1'b1};
                  end else if (count_ff == '0) begin
                     state_in = ST_SINS;
                  end else begin
                     state_in = ST_SRD;
                  end
               end else if (count_ff != '0) begin
                  first_in = 1'b1;
                  pend_in  = 1'b0;
                  state_in = ST_TRD;
               end
            end
         end
         ST_SRD: begin
            rd_addr  = pos_ff[IDX_W-1:0];
            state_in = ST_SCHK;
         end
         ST_SCHK: begin
            if (rem_ff >= rd_data.delta) begin
               rem_in = rem_ff - rd_data.delta;
               pos_in = pos_ff + 1'b1;
               state_in = (pos_ff + 1'b1 == count_ff) ? ST_SINS : ST_SRD;
            end else begin
               wr_en    = 1'b1;
               wr_addr  = pos_ff[IDX_W-1:0];
               wr_data  = '{rd_data.delta - rem_ff, rd_data.id};
               ptr_in   = count_ff;
               state_in = ST_SHRD;
            end
         end
         ST_SHRD: begin
            if (ptr_ff == pos_ff) begin
               state_in = ST_SINS;
            end else begin
               rd_addr  = IDX_W'(ptr_ff - 1'b1);
               state_in = ST_SHWR;
            end
         end
         ST_SHWR: begin
            wr_en    = 1'b1;
            wr_addr  = ptr_ff[IDX_W-1:0];
            wr_data  = rd_data;
            ptr_in   = ptr_ff - 1'b1;
            state_in = ST_SHRD;
         end
         ST_SINS: begin
            wr_en     = 1'b1;
            wr_addr   = pos_ff[IDX_W-1:0];
            wr_data   = '{rem_ff, id_ff};
            count_in  = count_ff + 1'b1;
            strobe_in = 1'b1;
            rsp_in    = '{KIND_SET_OK, id_ff, 1'b1};
            state_in  = ST_IDLE;
         end
         ST_TRD: begin
            rd_addr  = pos_ff[IDX_W-1:0];
            state_in = ST_TCHK;
         end
         ST_TCHK: begin
            first_in = 1'b0;
            expired  = first_ff ? (rd_data.delta <= 32'd1) : (rd_data.delta == '0);
            if (first_ff && rd_data.delta != '0) begin
               wr_en   = 1'b1;
               wr_addr = '0;
               wr_data = '{rd_data.delta - 32'd1, rd_data.id};
            end
            if (expired) begin
               if (pend_ff) begin
                  strobe_in = 1'b1;
                  rsp_in    = pword_ff;
               end
               pend_in  = 1'b1;
               pword_in = '{KIND_EXPIRED, rd_data.id, 1'b0};
               pos_in   = pos_ff + 1'b1;
               state_in = (pos_ff + 1'b1 == count_ff) ? ST_MVRD : ST_TRD;
            end else begin
               state_in = ST_MVRD;
            end
            nexp_in = pos_ff;
            ptr_in  = pos_ff;
            if (state_in == ST_MVRD) begin
               nexp_in = expired ? pos_ff + 1'b1 : pos_ff;
               ptr_in  = nexp_in;
            end
         end
         ST_MVRD: begin
            // held-back expiry word goes out here, marked last
            if (pend_ff) begin
               strobe_in   = 1'b1;
               rsp_in      = pword_ff;
               rsp_in.last = 1'b1;
               pend_in     = 1'b0;
            end
            if (nexp_ff == '0 || ptr_ff == count_ff) begin
               count_in = count_ff - nexp_ff;
               state_in = ST_IDLE;
            end else begin
               rd_addr  = ptr_ff[IDX_W-1:0];
               state_in = ST_MVWR;
            end
         end
         ST_MVWR: begin
            wr_en    = 1'b1;
            wr_addr  = IDX_W'(ptr_ff - nexp_ff);
            wr_data  = rd_data;
            ptr_in   = ptr_ff + 1'b1;
            state_in = ST_MVRD;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
         pend_ff   <= 1'b0;
         first_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
         pend_ff   <= pend_in;
         first_ff  <= first_in;
      end
      pos_ff   <= pos_in;
      ptr_ff   <= ptr_in;
      nexp_ff  <= nexp_in;
      rem_ff   <= rem_in;
      id_ff    <= id_in;
      pword_ff <= pword_in;
      rsp_ff   <= rsp_in;
   end
endmodule
